[rtl/rcsn_pkg.sv]
`timescale 1ns / 1ps

package rcsn_pkg;

  // Field and register widths
  localparam int RAW_W   = 11;
  localparam int DB_W    = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // Sample bits actually taken from the receiver word
  localparam int RAW_BITS = 11;
  localparam logic [RAW_W-1:0] RAW_MASK = RAW_W'((64'd1 << RAW_BITS) - 64'd1);

  // Scaling constants
  localparam int EDGE_MARGIN = 40;
  localparam int FULL_SCALE  = 1000;
  localparam int NUM_AXES    = 3;

  // Divider geometry: magnitude of (diff * 1000) and quotient width
  localparam int NUM_W     = 21;
  localparam int QUOT_W    = 11;
  localparam int DSH_W     = RAW_W + QUOT_W;
  localparam int DIV_STEPS = QUOT_W + 1;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Reset values of the configuration registers
  localparam logic [RAW_W-1:0] MINIMUM_RESET  = RAW_W'(172);
  localparam logic [RAW_W-1:0] MAXIMUM_RESET  = RAW_W'(1811);
  localparam logic [RAW_W-1:0] MIDPOINT_RESET = RAW_W'(992);
  localparam logic [DB_W-1:0]  DEADBAND_RESET = DB_W'(20);

  // Item kinds
  localparam logic [1:0] KIND_STICK    = 2'd0;
  localparam logic [1:0] KIND_THROTTLE = 2'd1;
  localparam logic [1:0] KIND_SET      = 2'd2;
  localparam logic [1:0] KIND_RESET    = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MINIMUM  = 2'd0;
  localparam logic [1:0] REG_MAXIMUM  = 2'd1;
  localparam logic [1:0] REG_MIDPOINT = 2'd2;
  localparam logic [1:0] REG_DEADBAND = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       axis;
    logic [RAW_W-1:0] raw_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] normalized_value;
    logic [RAW_W-1:0]        axis_center;
  } out_item_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_minimum;
    logic [RAW_W-1:0] raw_maximum;
    logic [RAW_W-1:0] raw_midpoint;
    logic [DB_W-1:0]  deadband_width;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic quick;
    logic div_last;
  } dp_status_t;

endpackage

[rtl/rcsn_regs.sv]
`timescale 1ns / 1ps

module rcsn_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rcsn_pkg::ADDR_W-1:0] paddr,
  input  logic [rcsn_pkg::DATA_W-1:0] pwdata,
  output logic [rcsn_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output rcsn_pkg::cfg_t             cfg
);
  import rcsn_pkg::*;

  logic       wr_en;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.raw_minimum    <= MINIMUM_RESET;
      cfg.raw_maximum    <= MAXIMUM_RESET;
      cfg.raw_midpoint   <= MIDPOINT_RESET;
      cfg.deadband_width <= DEADBAND_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_MINIMUM:  cfg.raw_minimum    <= pwdata[RAW_W-1:0];
        REG_MAXIMUM:  cfg.raw_maximum    <= pwdata[RAW_W-1:0];
        REG_MIDPOINT: cfg.raw_midpoint   <= pwdata[RAW_W-1:0];
        REG_DEADBAND: cfg.deadband_width <= pwdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Return the addressed register on a read
  always_comb begin
    case (idx)
      REG_MINIMUM:  prdata = DATA_W'(cfg.raw_minimum);
      REG_MAXIMUM:  prdata = DATA_W'(cfg.raw_maximum);
      REG_MIDPOINT: prdata = DATA_W'(cfg.raw_midpoint);
      REG_DEADBAND: prdata = DATA_W'(cfg.deadband_width);
      default:      prdata = '0;
    endcase
  end

endmodule

[rtl/rcsn_ctrl.sv]
`timescale 1ns / 1ps

module rcsn_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  rcsn_pkg::dp_status_t   status,
  output rcsn_pkg::ctrl_cmd_t    cmd
);
  import rcsn_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  // State and output flag registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Sequence one transaction: operands, multiply, divide, result; set and reset skip multiply and divide
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.quick ? S_FIN : S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall       = (state != S_IDLE);
  assign out_valid_next = cmd.finish | (out_valid & out_stall);

endmodule

[rtl/rcsn_datapath.sv]
`timescale 1ns / 1ps

module rcsn_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rcsn_pkg::cfg_t       cfg,
  input  rcsn_pkg::in_item_t   in_item,
  input  rcsn_pkg::ctrl_cmd_t  cmd,
  output rcsn_pkg::dp_status_t status,
  output rcsn_pkg::out_item_t  out_item
);
  import rcsn_pkg::*;

  // Captured transaction
  logic [1:0]       kind_q;
  logic [1:0]       axis_q;
  logic [RAW_W-1:0] raw_q;

  // Operands
  logic             neg_q;
  logic [RAW_W-1:0] mag_q;
  logic [RAW_W-1:0] span_q;

  // Divider
  logic [NUM_W-1:0]  rem_q;
  logic [DSH_W-1:0]  dsh_q;
  logic [CNT_W-1:0]  cnt;
  logic              sat_q;
  logic [QUOT_W-1:0] quot_q;

  // Stored centers
  logic [RAW_W-1:0] centers [NUM_AXES];

  logic             has_center;
  logic [RAW_W-1:0] center_cur;
  logic             ge;
  logic [RAW_W:0]   span_raw;
  logic [RAW_W-1:0] span_clamp;
  logic [RAW_W-1:0] mag_next;
  logic             neg_next;
  logic [NUM_W-1:0] product;
  logic [DSH_W:0]   div_diff;
  logic             div_bit;
  logic [QUOT_W-1:0] capped;
  logic [QUOT_W-1:0] res_mag;
  logic             res_neg;
  logic [RAW_W-1:0] norm;
  logic             low_edge;
  logic             high_edge;
  logic [RAW_W-1:0] cal;
  logic [RAW_W-1:0] center_out;

  // Read the center of the captured axis; the unused axis code reads the midpoint
  assign has_center = (axis_q < 2'(NUM_AXES));
  always_comb begin
    case (axis_q)
      2'd0:    center_cur = centers[0];
      2'd1:    center_cur = centers[1];
      2'd2:    center_cur = centers[2];
      default: center_cur = cfg.raw_midpoint;
    endcase
  end

  // Form magnitude, sign and divisor for stick or throttle
  always_comb begin
    if (kind_q == KIND_STICK) begin
      ge       = (raw_q >= center_cur);
      span_raw = ge ? ({1'b0, cfg.raw_maximum} - {1'b0, center_cur})
                    : ({1'b0, center_cur} - {1'b0, cfg.raw_minimum});
      mag_next = ge ? (raw_q - center_cur) : (center_cur - raw_q);
    end else begin
      ge       = (raw_q >= cfg.raw_minimum);
      span_raw = {1'b0, cfg.raw_maximum} - {1'b0, cfg.raw_minimum};
      mag_next = ge ? (raw_q - cfg.raw_minimum) : '0;
    end
    neg_next = ~ge;
    // clamp a negative or zero span to one
    if (span_raw[RAW_W] || (span_raw == '0)) begin
      span_clamp = RAW_W'(1);
    end else begin
      span_clamp = span_raw[RAW_W-1:0];
    end
  end

  assign product = NUM_W'(mag_q) * NUM_W'(FULL_SCALE);

  // One restoring step: compare against the shifted divisor
  assign div_diff = {1'b0, DSH_W'(rem_q)} - {1'b0, dsh_q};
  assign div_bit  = ~div_diff[DSH_W];

  assign status.quick    = (kind_q == KIND_SET) || (kind_q == KIND_RESET);
  assign status.div_last = (cnt == CNT_W'(DIV_STEPS - 1));

  // Saturate, apply deadband and sign
  always_comb begin
    if (sat_q || (quot_q > QUOT_W'(FULL_SCALE))) begin
      capped = QUOT_W'(FULL_SCALE);
    end else begin
      capped = quot_q;
    end
    case (kind_q)
      KIND_STICK: begin
        res_mag = (!sat_q && (quot_q < QUOT_W'(cfg.deadband_width))) ? '0 : capped;
        res_neg = neg_q;
      end
      KIND_THROTTLE: begin
        res_mag = neg_q ? '0 : capped;
        res_neg = 1'b0;
      end
      default: begin
        res_mag = '0;
        res_neg = 1'b0;
      end
    endcase
    norm = res_neg ? (RAW_W'(0) - RAW_W'(res_mag)) : RAW_W'(res_mag);
  end

  // Calibrated center: fall back to the midpoint near either limit
  assign low_edge  = ({1'b0, raw_q} <= ({1'b0, cfg.raw_minimum} + (RAW_W+1)'(EDGE_MARGIN)));
  assign high_edge = (({1'b0, raw_q} + (RAW_W+1)'(EDGE_MARGIN)) >= {1'b0, cfg.raw_maximum});
  assign cal       = (low_edge || high_edge) ? cfg.raw_midpoint : raw_q;

  always_comb begin
    case (kind_q)
      KIND_SET:   center_out = has_center ? cal : cfg.raw_midpoint;
      KIND_RESET: center_out = cfg.raw_midpoint;
      default:    center_out = center_cur;
    endcase
  end

  // Capture, operand, multiply, divider and output registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_item.kind;
      axis_q <= in_item.axis;
      raw_q  <= in_item.raw_sample & RAW_MASK;
    end
    if (cmd.prep) begin
      neg_q  <= neg_next;
      mag_q  <= mag_next;
      span_q <= span_clamp;
    end
    if (cmd.mul) begin
      rem_q  <= product;
      dsh_q  <= {span_q, QUOT_W'(0)};
      cnt    <= '0;
      sat_q  <= 1'b0;
      quot_q <= '0;
    end else if (cmd.div_step) begin
      if (div_bit) begin
        rem_q <= div_diff[NUM_W-1:0];
      end
      // first step only flags a quotient beyond the result width
      if (cnt == '0) begin
        sat_q <= div_bit;
      end else begin
        quot_q <= {quot_q[QUOT_W-2:0], div_bit};
      end
      dsh_q <= dsh_q >> 1;
      cnt   <= cnt + CNT_W'(1);
    end
    if (cmd.finish) begin
      out_item.normalized_value <= norm;
      out_item.axis_center      <= center_out;
    end
  end

  // Update stored centers when the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        centers[i] <= MIDPOINT_RESET;
      end
    end else if (cmd.finish) begin
      if (kind_q == KIND_RESET) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          centers[i] <= cfg.raw_midpoint;
        end
      end else if ((kind_q == KIND_SET) && has_center) begin
        for (int i = 0; i < NUM_AXES; i++) begin
          if (axis_q == 2'(i)) begin
            centers[i] <= cal;
          end
        end
      end
    end
  end

endmodule

[rtl/rc_stick_normalizer.sv]
`timescale 1ns / 1ps

// Radio-control stick normalizer.
// Input channel (in_valid / in_stall / in_item) carries one sample with its
// kind and axis; output channel (out_valid / out_stall / out_item) returns
// exactly one result per input transaction, in order.
// Stick items give -1000..1000 around the stored axis center with deadband;
// throttle items give 0..1000; set and reset items update the centers and
// return 0 with the resulting center.
// Configuration goes through the APB port: minimum at 0x0, maximum at 0x4,
// midpoint at 0x8, deadband at 0xC. Write only while the block is idle.
// Stick and throttle pass through one operand step, one multiply and 12 steps
// of the shared radix-2 divider, then the result step; set and reset go from
// the operand step straight to the result step. A new item is taken only
// after the current one has left its result step.
// A result waits in the output register while out_stall is high; the next
// item is still taken and worked on, and holds in its last cycle until the
// register frees. Synchronous reset restores the register defaults, sets all
// centers to 992 and empties the pipeline.
module rc_stick_normalizer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rcsn_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rcsn_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcsn_pkg::ADDR_W-1:0] paddr,
  input  logic [rcsn_pkg::DATA_W-1:0] pwdata,
  output logic [rcsn_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import rcsn_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  rcsn_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcsn_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rcsn_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

[rtl/rcsn_checker.sv]
`timescale 1ns / 1ps

module rcsn_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input rcsn_pkg::in_item_t  in_item,
  input logic                out_valid,
  input logic                out_stall,
  input rcsn_pkg::out_item_t out_item
);
  import rcsn_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed or dropped");

  // An accepted transaction keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // A new result only appears while a transaction is in flight
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in flight");

  // Results stay within full scale
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(out_item.normalized_value) >= -11'sd1000) &&
                  ($signed(out_item.normalized_value) <= 11'sd1000))
    else $error("normalized value out of range");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind rc_stick_normalizer rcsn_checker u_rcsn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

[tb/sv/tb_rc_stick_normalizer.sv]
`timescale 1ns / 1ps

module tb_rc_stick_normalizer;
  import rcsn_pkg::*;

  localparam int CLK_HALF_NS   = 2;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 83;
  localparam int NUM_PHASES    = 10;
  localparam int REPORT_LIMIT  = 10;
  localparam longint RUN_LIMIT_NS = 64'd2_000_000;

  // One directed transaction, with its typed-in result where it is obvious
  typedef struct packed {
    logic [1:0]              kind;
    logic [1:0]              axis;
    logic [RAW_W-1:0]        raw;
    logic                    typed;
    logic signed [RAW_W-1:0] want_value;
    logic [RAW_W-1:0]        want_center;
  } opening_row_t;

  // Calibration used in one phase; randomized rows draw their own values
  typedef struct packed {
    logic [RAW_W-1:0] minimum;
    logic [RAW_W-1:0] maximum;
    logic [RAW_W-1:0] midpoint;
    logic [DB_W-1:0]  deadband;
    logic             randomized;
  } calibration_row_t;

  localparam opening_row_t OPENING [25] = '{
    '{KIND_STICK,    2'd0, 11'd992,  1'b1, 11'sd0,     11'd992},
    '{KIND_STICK,    2'd0, 11'd2047, 1'b1, 11'sd1000,  11'd992},
    '{KIND_STICK,    2'd0, 11'd0,    1'b1, -11'sd1000, 11'd992},
    '{KIND_THROTTLE, 2'd0, 11'd172,  1'b1, 11'sd0,     11'd992},
    '{KIND_THROTTLE, 2'd1, 11'd1811, 1'b1, 11'sd1000,  11'd992},
    '{KIND_THROTTLE, 2'd2, 11'd0,    1'b1, 11'sd0,     11'd992},
    '{KIND_THROTTLE, 2'd3, 11'd2047, 1'b1, 11'sd1000,  11'd992},
    '{KIND_STICK,    2'd1, 11'd1000, 1'b1, 11'sd0,     11'd992},
    '{KIND_STICK,    2'd2, 11'd1010, 1'b0, 11'sd0,     11'd0},
    '{KIND_STICK,    2'd3, 11'd500,  1'b0, 11'sd0,     11'd0},
    '{KIND_SET,      2'd0, 11'd212,  1'b1, 11'sd0,     11'd992},
    '{KIND_SET,      2'd0, 11'd213,  1'b1, 11'sd0,     11'd213},
    '{KIND_SET,      2'd1, 11'd1771, 1'b1, 11'sd0,     11'd992},
    '{KIND_SET,      2'd1, 11'd1770, 1'b1, 11'sd0,     11'd1770},
    '{KIND_SET,      2'd3, 11'd1500, 1'b1, 11'sd0,     11'd992},
    '{KIND_STICK,    2'd0, 11'd213,  1'b1, 11'sd0,     11'd213},
    '{KIND_STICK,    2'd0, 11'd100,  1'b1, -11'sd1000, 11'd213},
    '{KIND_STICK,    2'd1, 11'd1811, 1'b0, 11'sd0,     11'd0},
    '{KIND_STICK,    2'd1, 11'd1700, 1'b0, 11'sd0,     11'd0},
    '{KIND_THROTTLE, 2'd0, 11'd991,  1'b0, 11'sd0,     11'd0},
    '{KIND_RESET,    2'd2, 11'd0,    1'b1, 11'sd0,     11'd992},
    '{KIND_STICK,    2'd0, 11'd213,  1'b0, 11'sd0,     11'd0},
    '{KIND_SET,      2'd2, 11'd2047, 1'b1, 11'sd0,     11'd992},
    '{KIND_SET,      2'd2, 11'd1024, 1'b1, 11'sd0,     11'd1024},
    '{KIND_STICK,    2'd2, 11'd1044, 1'b0, 11'sd0,     11'd0}
  };

  localparam calibration_row_t CALIBRATIONS [NUM_PHASES] = '{
    '{11'd172,  11'd1811, 11'd992,  10'd20,   1'b0},
    '{11'd0,    11'd2047, 11'd1024, 10'd0,    1'b0},
    '{11'd0,    11'd2047, 11'd0,    10'd1000, 1'b0},
    '{11'd2047, 11'd2047, 11'd2047, 10'd1,    1'b0},
    '{11'd1000, 11'd900,  11'd950,  10'd50,   1'b0},
    '{11'd2047, 11'd0,    11'd0,    10'd1000, 1'b0},
    '{11'd0,    11'd0,    11'd0,    10'd0,    1'b1},
    '{11'd0,    11'd0,    11'd0,    10'd0,    1'b1},
    '{11'd0,    11'd0,    11'd0,    10'd0,    1'b1},
    '{11'd0,    11'd0,    11'd0,    10'd0,    1'b1}
  };

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_item_t          in_item   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_item;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr     = '0;
  logic [DATA_W-1:0] pwdata    = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Shadow of the block: calibration registers and stored centers
  cfg_t             cal;
  logic [RAW_W-1:0] axis_centers [NUM_AXES];

  out_item_t pending_results [$];
  int        mismatches = 0;
  int        quiet_left = 0;

  rc_stick_normalizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

  // Compute the result of one transaction and update the shadow centers
  function automatic out_item_t normalize_sample(in_item_t it);
    out_item_t res;
    int r, c, lo, hi, db, span, v;
    r    = int'(it.raw_sample & RAW_MASK);
    lo   = int'(cal.raw_minimum);
    hi   = int'(cal.raw_maximum);
    db   = int'(cal.deadband_width);
    v    = 0;
    case (it.kind)
      KIND_STICK: begin
        c = (it.axis < NUM_AXES) ? int'(axis_centers[it.axis]) : int'(cal.raw_midpoint);
        span = (r >= c) ? hi - c : c - lo;
        if (span < 1) span = 1;
        v = ((r - c) * FULL_SCALE) / span;
        if (v > -db && v < db) v = 0;
        if (v < -FULL_SCALE) v = -FULL_SCALE;
        if (v > FULL_SCALE) v = FULL_SCALE;
      end
      KIND_THROTTLE: begin
        span = hi - lo;
        if (span < 1) span = 1;
        v = ((r - lo) * FULL_SCALE) / span;
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
      end
      KIND_SET: begin
        // Samples close to either limit fall back to the midpoint
        if (it.axis < NUM_AXES) begin
          if (r <= lo + EDGE_MARGIN || r >= hi - EDGE_MARGIN)
            axis_centers[it.axis] = cal.raw_midpoint;
          else
            axis_centers[it.axis] = RAW_W'(r);
        end
      end
      default: begin
        for (int i = 0; i < NUM_AXES; i++) axis_centers[i] = cal.raw_midpoint;
      end
    endcase
    res.normalized_value = v[RAW_W-1:0];
    res.axis_center = (it.axis < NUM_AXES) ? axis_centers[it.axis] : cal.raw_midpoint;
    return res;
  endfunction

  // Draw a transaction; samples cluster on limits, edge margins and deadband
  function automatic in_item_t random_sample();
    in_item_t it;
    int pick, lo, hi, center, reach, raw;
    pick = $urandom_range(0, 99);
    if (pick < 45)      it.kind = KIND_STICK;
    else if (pick < 65) it.kind = KIND_THROTTLE;
    else if (pick < 93) it.kind = KIND_SET;
    else                it.kind = KIND_RESET;
    it.axis = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    lo = int'(cal.raw_minimum);
    hi = int'(cal.raw_maximum);
    center = (it.axis < NUM_AXES) ? int'(axis_centers[it.axis]) : int'(cal.raw_midpoint);
    reach = (int'(cal.deadband_width) * ((hi > lo) ? hi - lo : lo - hi)) / 2000 + 3;
    pick = $urandom_range(0, 99);
    if (pick < 25)      raw = $urandom_range(0, (1 << RAW_W) - 1);
    else if (pick < 55) raw = $urandom_range(lo, hi);
    else if (pick < 65) raw = lo + EDGE_MARGIN + $urandom_range(0, 4) - 2;
    else if (pick < 75) raw = hi - EDGE_MARGIN + $urandom_range(0, 4) - 2;
    else if (pick < 80) raw = ($urandom_range(0, 1) == 0) ? lo : hi;
    else                raw = center + $urandom_range(0, 2 * reach) - reach;
    it.raw_sample = RAW_W'(raw);
    return it;
  endfunction

  function automatic int pick_gap();
    int pick;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Present one transaction, hold it until taken, then queue its result
  task automatic send_sample(input in_item_t it, input logic typed, input out_item_t typed_result);
    int gap;
    out_item_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = normalize_sample(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_results_done();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic settle_pipeline();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [1:0] index, input int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_MINIMUM:  cal.raw_minimum    = RAW_W'(value);
      REG_MAXIMUM:  cal.raw_maximum    = RAW_W'(value);
      REG_MIDPOINT: cal.raw_midpoint   = RAW_W'(value);
      default:      cal.deadband_width = DB_W'(value);
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_calibration(input calibration_row_t row);
    int lo, hi, mid, db;
    lo  = int'(row.minimum);
    hi  = int'(row.maximum);
    mid = int'(row.midpoint);
    db  = int'(row.deadband);
    if (row.randomized) begin
      lo  = $urandom_range(0, 900);
      hi  = $urandom_range(1100, (1 << RAW_W) - 1);
      mid = $urandom_range(lo, hi);
      db  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, FULL_SCALE) : $urandom_range(0, 60);
    end
    apb_write(REG_MINIMUM, lo);
    apb_write(REG_MAXIMUM, hi);
    apb_write(REG_MIDPOINT, mid);
    apb_write(REG_DEADBAND, db);
  endtask

  // Receiver backpressure: free runs, choppy stretches and long holds
  initial begin
    int mode, len;
    forever begin
      mode = $urandom_range(0, 99);
      if (mode < 35) begin
        len = $urandom_range(5, 40);
        repeat (len) begin
          @(negedge clk);
          out_stall <= 1'b0;
        end
      end else if (mode < 88) begin
        len = $urandom_range(5, 30);
        repeat (len) begin
          @(negedge clk);
          out_stall <= ($urandom_range(0, 2) == 0);
        end
      end else begin
        len = $urandom_range(10, 60);
        repeat (len) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
    end
  end

  // Compare each taken result with the oldest pending one
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: value %0d center %0d",
                   out_item.normalized_value, out_item.axis_center);
      end else begin
        want = pending_results.pop_front();
        if (out_item.normalized_value !== want.normalized_value ||
            out_item.axis_center !== want.axis_center) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: value exp %0d got %0d, center exp %0d got %0d",
                     want.normalized_value, out_item.normalized_value,
                     want.axis_center, out_item.axis_center);
        end
      end
    end
  end

  initial begin
    in_item_t  it;
    out_item_t typed_result;
    cal.raw_minimum    = MINIMUM_RESET;
    cal.raw_maximum    = MAXIMUM_RESET;
    cal.raw_midpoint   = MIDPOINT_RESET;
    cal.deadband_width = DEADBAND_RESET;
    for (int i = 0; i < NUM_AXES; i++) axis_centers[i] = MIDPOINT_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table under the reset calibration
    foreach (OPENING[i]) begin
      it.kind       = OPENING[i].kind;
      it.axis       = OPENING[i].axis;
      it.raw_sample = OPENING[i].raw;
      typed_result.normalized_value = OPENING[i].want_value;
      typed_result.axis_center      = OPENING[i].want_center;
      send_sample(it, OPENING[i].typed, typed_result);
    end

    // Random transactions, one calibration per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_pipeline();
      program_calibration(CALIBRATIONS[ph]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) wait_results_done();
        send_sample(random_sample(), 1'b0, '0);
      end
    end

    settle_pipeline();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
